@@ rtl/afk_pkg.sv @@
// ----------------------------------------------------------------------------
// afk_pkg
// Types, constants and helpers shared by the arm forward kinematics block.
// ----------------------------------------------------------------------------
`default_nettype none

package afk_pkg;

   localparam int ANGLE_W = 16;
   localparam int LEN_W   = 20;
   localparam int POS_W   = 23;
   localparam int TRIG_W  = 34;
   localparam int Z_W     = 37;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam longint CORDIC_GAIN = 64'sd652032874;

   localparam logic signed [Z_W-1:0] Q30_PI      = 37'sd3373259426;
   localparam logic signed [Z_W-1:0] Q30_HALF_PI = 37'sd1686629713;
   localparam logic signed [Z_W-1:0] Q30_TWO_PI  = 37'sd6746518852;

   localparam logic signed [POS_W-1:0] POS_MAX = 23'sd4194303;
   localparam logic signed [POS_W-1:0] POS_MIN = -23'sd4194304;

   typedef enum logic [1:0] {
      REG_BASE_HEIGHT = 2'd0,
      REG_UPPER_LINK  = 2'd1,
      REG_FORE_LINK   = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [LEN_W-1:0] base_height;
      logic [LEN_W-1:0] upper_link_length;
      logic [LEN_W-1:0] fore_link_length;
   } link_cfg_type;

   localparam logic [31:0] ATAN_Q30 [0:23] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
      32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
      32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
      32'd262144,    32'd131072,    32'd65536,     32'd32768,
      32'd16384,     32'd8192,      32'd4096,      32'd2048,
      32'd1024,      32'd512,       32'd256,       32'd128
   };

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [27:0] v);
      logic signed [POS_W-1:0] r;
      if (v > 28'(signed'(POS_MAX))) begin
         r = POS_MAX;
      end else if (v < 28'(signed'(POS_MIN))) begin
         r = POS_MIN;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/afk_if.sv @@
// ----------------------------------------------------------------------------
// afk_req_if / afk_rsp_if
// Valid/ready channels for joint angles and tool positions.
// ----------------------------------------------------------------------------
`default_nettype none

interface afk_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [afk_pkg::ANGLE_W-1:0]    angle_base;
   logic signed [afk_pkg::ANGLE_W-1:0]    angle_shoulder;
   logic signed [afk_pkg::ANGLE_W-1:0]    angle_elbow;
   modport source (output valid, angle_base, angle_shoulder, angle_elbow, input ready);
   modport sink   (input valid, angle_base, angle_shoulder, angle_elbow, output ready);
endinterface

interface afk_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [afk_pkg::POS_W-1:0]    pos_x;
   logic signed [afk_pkg::POS_W-1:0]    pos_y;
   logic signed [afk_pkg::POS_W-1:0]    pos_z;
   modport source (output valid, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

`default_nettype wire

@@ rtl/afk_csr.sv @@
// ----------------------------------------------------------------------------
// afk_csr
// APB register file holding the three link lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module afk_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [afk_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [afk_pkg::DATA_W-1:0]    pwdata,
   output      logic [afk_pkg::DATA_W-1:0]    prdata,
   output      logic                          pready,
   output      afk_pkg::link_cfg_type         cfg
);

   afk_pkg::link_cfg_type cfg_ff, cfg_in;
   logic                  wr;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (paddr[3:2])
            afk_pkg::REG_BASE_HEIGHT: cfg_in.base_height       = pwdata[afk_pkg::LEN_W-1:0];
            afk_pkg::REG_UPPER_LINK:  cfg_in.upper_link_length = pwdata[afk_pkg::LEN_W-1:0];
            afk_pkg::REG_FORE_LINK:   cfg_in.fore_link_length  = pwdata[afk_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         afk_pkg::REG_BASE_HEIGHT: prdata = 32'(cfg_ff.base_height);
         afk_pkg::REG_UPPER_LINK:  prdata = 32'(cfg_ff.upper_link_length);
         afk_pkg::REG_FORE_LINK:   prdata = 32'(cfg_ff.fore_link_length);
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_height       <= 20'd8975;
         cfg_ff.upper_link_length <= 20'd47616;
         cfg_ff.fore_link_length  <= 20'd35853;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/afk_cordic.sv @@
// ----------------------------------------------------------------------------
// afk_cordic
// Pipelined sine/cosine: range reduction, one register per CORDIC step,
// quadrant fix-up. Advances when en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module afk_cordic #(
   parameter int NS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               en,
   input  wire logic signed [16:0]                 angle,
   output      logic signed [afk_pkg::TRIG_W-1:0]  cos_q30,
   output      logic signed [afk_pkg::TRIG_W-1:0]  sin_q30
);

   localparam int  TW = afk_pkg::TRIG_W;
   localparam int  ZW = afk_pkg::Z_W;
   localparam longint X0 = afk_pkg::CORDIC_GAIN
                          + ((2 * afk_pkg::CORDIC_GAIN / 3) >> (2 * NS));

   logic signed [TW-1:0] x_ff [0:NS];
   logic signed [TW-1:0] y_ff [0:NS];
   logic signed [ZW-1:0] z_ff [0:NS];
   logic                 neg_ff [0:NS];
   logic signed [TW-1:0] cos_ff, sin_ff;

   logic signed [ZW-1:0] z0, z1, z_in;
   logic                 neg_in;

   always_comb begin
      z0 = ZW'(angle) <<< 17;
      if (z0 > afk_pkg::Q30_PI) begin
         z1 = z0 - afk_pkg::Q30_TWO_PI;
      end else if (z0 < -afk_pkg::Q30_PI) begin
         z1 = z0 + afk_pkg::Q30_TWO_PI;
      end else begin
         z1 = z0;
      end
      neg_in = 1'b0;
      z_in   = z1;
      if (z1 > afk_pkg::Q30_HALF_PI) begin
         z_in   = z1 - afk_pkg::Q30_PI;
         neg_in = 1'b1;
      end else if (z1 < -afk_pkg::Q30_HALF_PI) begin
         z_in   = z1 + afk_pkg::Q30_PI;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= TW'(X0);
         y_ff[0]   <= '0;
         z_ff[0]   <= z_in;
         neg_ff[0] <= neg_in;
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_step
      localparam logic signed [ZW-1:0] ATAN = ZW'(afk_pkg::ATAN_Q30[i]);
      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN;
            end
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= neg_ff[NS] ? -x_ff[NS] : x_ff[NS];
         sin_ff <= neg_ff[NS] ? -y_ff[NS] : y_ff[NS];
      end
   end

   assign cos_q30 = cos_ff;
   assign sin_q30 = sin_ff;

endmodule

`default_nettype wire

@@ rtl/arm_forward_kinematics.sv @@
// Throughput: one transfer per cycle unless the output stalls; three CORDIC
// pipelines run side by side, then a product stage, a sum/round stage, a scale
// stage and the output register.
// The whole pipeline holds when the output register is full and not taken.
// Reset: synchronous, clears valid bits and loads link lengths to defaults.
// ----------------------------------------------------------------------------
// arm_forward_kinematics
// Tool point of a three-link arm from base, shoulder and elbow angles.
// ----------------------------------------------------------------------------
`default_nettype none

module arm_forward_kinematics #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   afk_req_if.sink                            req,
   afk_rsp_if.source                          rsp,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [afk_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [afk_pkg::DATA_W-1:0]    pwdata,
   output      logic [afk_pkg::DATA_W-1:0]    prdata,
   output      logic                          pready
);

   localparam int LAT = CORDIC_STAGES + 6;
   localparam int TW  = afk_pkg::TRIG_W;

   afk_pkg::link_cfg_type cfg;
   logic                  en;
   logic [LAT-1:0]        vld_ff;

   logic signed [TW-1:0] c1, s1, c2, s2, c23, s23;
   logic signed [16:0]   a23;

   logic signed [20:0]   l1, l2, l3;
   logic signed [54:0]   pr2_ff, pr3_ff, py2_ff, py3_ff;
   logic signed [TW-1:0] c1m_ff, s1m_ff, c1s_ff, s1s_ff;
   logic signed [55:0]   sr, sy;
   logic signed [30:0]   reach_ff;
   logic signed [55:0]   sr_rnd, sy_rnd;
   logic signed [24:0]   py_in;
   logic signed [afk_pkg::POS_W-1:0] py_s_ff, py_p_ff;
   logic signed [64:0]   px_prod_ff, pz_prod_ff;
   logic signed [64:0]   px_rnd, pz_rnd;
   logic signed [afk_pkg::POS_W-1:0] px_ff, py_ff, pz_ff;

   afk_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata,
      .prdata, .pready, .cfg
   );

   assign en        = !rsp.valid || rsp.ready;
   assign req.ready = en;
   assign rsp.valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req.valid};
      end
   end

   assign a23 = 17'(req.angle_shoulder) + 17'(req.angle_elbow);

   afk_cordic #(.NS(CORDIC_STAGES)) u_cordic_base (
      .clock, .en, .angle(17'(req.angle_base)), .cos_q30(c1), .sin_q30(s1)
   );
   afk_cordic #(.NS(CORDIC_STAGES)) u_cordic_shoulder (
      .clock, .en, .angle(17'(req.angle_shoulder)), .cos_q30(c2), .sin_q30(s2)
   );
   afk_cordic #(.NS(CORDIC_STAGES)) u_cordic_elbow (
      .clock, .en, .angle(a23), .cos_q30(c23), .sin_q30(s23)
   );

   assign l1 = signed'({1'b0, cfg.base_height});
   assign l2 = signed'({1'b0, cfg.upper_link_length});
   assign l3 = signed'({1'b0, cfg.fore_link_length});

   // link products
   always_ff @(posedge clock) begin
      if (en) begin
         pr2_ff <= 55'(l2) * 55'(s2);
         pr3_ff <= 55'(l3) * 55'(s23);
         py2_ff <= 55'(l2) * 55'(c2);
         py3_ff <= 55'(l3) * 55'(c23);
         c1m_ff <= c1;
         s1m_ff <= s1;
      end
   end

   // sums and rounding
   assign sr     = 56'(pr2_ff) + 56'(pr3_ff);
   assign sy     = 56'(py2_ff) + 56'(py3_ff);
   assign sr_rnd = (sr + 56'sd2097152) >>> 22;
   assign sy_rnd = (sy + 56'sd536870912) >>> 30;
   assign py_in  = 25'(l1) + 25'(signed'(sy_rnd[23:0]));

   always_ff @(posedge clock) begin
      if (en) begin
         reach_ff <= sr_rnd[30:0];
         py_s_ff  <= afk_pkg::sat_pos(28'(py_in));
         c1s_ff   <= c1m_ff;
         s1s_ff   <= s1m_ff;
      end
   end

   // base rotation
   always_ff @(posedge clock) begin
      if (en) begin
         px_prod_ff <= 65'(c1s_ff) * 65'(reach_ff);
         pz_prod_ff <= -(65'(s1s_ff) * 65'(reach_ff));
         py_p_ff    <= py_s_ff;
      end
   end

   assign px_rnd = (px_prod_ff + (65'sd1 <<< 37)) >>> 38;
   assign pz_rnd = (pz_prod_ff + (65'sd1 <<< 37)) >>> 38;

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= afk_pkg::sat_pos(px_rnd[27:0]);
         pz_ff <= afk_pkg::sat_pos(pz_rnd[27:0]);
         py_ff <= py_p_ff;
      end
   end

   assign rsp.pos_x = px_ff;
   assign rsp.pos_y = py_ff;
   assign rsp.pos_z = pz_ff;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("rsp valid after reset");
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during stall");
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req.ready == (!rsp.valid || rsp.ready))
      else $error("req ready disagrees with output stage");

endmodule

`default_nettype wire
